// File: design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants and types for the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int ADDR_W      = 32;
   localparam int SET_BITS    = 6;
   localparam int OFFSET_BITS = 5;
   localparam int WAYS        = 4;
   localparam int TAG_W       = ADDR_W - SET_BITS - OFFSET_BITS;
   localparam int SETS        = 1 << SET_BITS;
   localparam int WAY_W       = 2;
   localparam int AGE_W       = 2;

   localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);

   typedef struct packed {
      logic                   valid;
      logic [AGE_W-1:0]       age;
      logic [TAG_W-1:0]       tag;
      logic [OFFSET_BITS-1:0] offset;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic load;
      logic update;
   } cmd_type;

endpackage

// File: design/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: accepts a transaction, then runs the set update and strobes.
// ----------------------------------------------------------------------------
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   output logic    rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign strobe_in  = cmd.update;
   assign busy       = (state_ff == ST_LOOKUP);
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

// File: design/sacl_dpath.sv
// ----------------------------------------------------------------------------
// sacl_dpath
// Set memory, tag compare, victim choice, age update and result registers.
// ----------------------------------------------------------------------------
module sacl_dpath
   import sacl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [ADDR_W-1:0]   req_addr,
   output logic                rsp_hit,
   output logic [WAY_W-1:0]    rsp_way,
   output logic [TAG_W-1:0]    rsp_tag_value,
   output logic                rsp_fill_request,
   output logic [ADDR_W-1:0]   rsp_fill_addr,
   output logic                rsp_evicted,
   output logic [ADDR_W-1:0]   rsp_evicted_addr
);

   row_type                 mem [SETS];
   row_type                 rd_row_ff;
   logic                    rd_touched_ff;
   logic [SETS-1:0]         touched_ff;
   logic [ADDR_W-1:0]       addr_ff;

   logic [SET_BITS-1:0]     req_set;
   logic [TAG_W-1:0]        tag_a;
   logic [SET_BITS-1:0]     set_a;
   logic [OFFSET_BITS-1:0]  off_a;
   row_type                 cur_row;
   row_type                 new_row;
   logic                    hit;
   logic [WAY_W-1:0]        hit_way;
   logic                    any_inv;
   logic [WAY_W-1:0]        inv_way;
   logic [AGE_W-1:0]        best_age;
   logic [WAY_W-1:0]        old_way;
   logic [WAY_W-1:0]        sel;
   logic [AGE_W-1:0]        limit;
   logic                    evict;
   logic [ADDR_W-1:0]       evict_addr;

   logic                    hit_ff;
   logic [WAY_W-1:0]        way_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [ADDR_W-1:0]       fill_addr_ff;
   logic                    evicted_ff;
   logic [ADDR_W-1:0]       evicted_addr_ff;

   assign req_set = req_addr[OFFSET_BITS +: SET_BITS];
   assign tag_a   = addr_ff[ADDR_W-1 -: TAG_W];
   assign set_a   = addr_ff[OFFSET_BITS +: SET_BITS];
   assign off_a   = addr_ff[OFFSET_BITS-1:0];
   assign cur_row = rd_touched_ff ? rd_row_ff : '0;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      any_inv = 1'b0;
      inv_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (cur_row[w].valid && (cur_row[w].tag == tag_a)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!cur_row[w].valid) begin
            any_inv = 1'b1;
            inv_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      best_age = '0;
      old_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (cur_row[w].age > best_age) begin
            best_age = cur_row[w].age;
            old_way  = WAY_W'(w);
         end
      end
   end

   always_comb begin
      priority if (hit) begin
         sel = hit_way;
      end else if (any_inv) begin
         sel = inv_way;
      end else begin
         sel = old_way;
      end
   end

   assign limit      = hit ? cur_row[hit_way].age : OLDEST;
   assign evict      = !hit && !any_inv;
   assign evict_addr = {cur_row[sel].tag, set_a, cur_row[sel].offset};

   always_comb begin
      new_row = cur_row;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == sel) begin
            new_row[w].age = '0;
            if (!hit) begin
               new_row[w].valid  = 1'b1;
               new_row[w].tag    = tag_a;
               new_row[w].offset = off_a;
            end
         end else if (cur_row[w].age < limit) begin
            new_row[w].age = cur_row[w].age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[set_a] <= new_row;
      end
      if (cmd.load) begin
         rd_row_ff     <= mem[req_set];
         rd_touched_ff <= touched_ff[req_set];
         addr_ff       <= req_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
      end else if (cmd.update) begin
         touched_ff[set_a] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hit_ff          <= hit;
         way_ff          <= sel;
         tag_ff          <= tag_a;
         fill_addr_ff    <= hit ? '0 : addr_ff;
         evicted_ff      <= evict;
         evicted_addr_ff <= evict ? evict_addr : '0;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_way          = way_ff;
   assign rsp_tag_value    = tag_ff;
   assign rsp_fill_request = !hit_ff;
   assign rsp_fill_addr    = fill_addr_ff;
   assign rsp_evicted      = evicted_ff;
   assign rsp_evicted_addr = evicted_addr_ff;

endmodule

// File: design/set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Read lookup of a 4-way set-associative cache level with true LRU ages.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_addr      in         start && !busy
//   response  rsp_strobe, rsp_*          out        rsp_strobe, one cycle
//
// For each transaction the set row is read from the set memory on
// the accepting edge, compared, aged and written back in the next cycle.
// The response strobes in the cycle after that, while busy is already low,
// so a new transaction can be accepted while the last response is shown.
// Reset clears the per-set touched flags at once; no clearing pass.
// The receiver cannot stall; each response is shown for one cycle only.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup
   import sacl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ADDR_W-1:0]   req_addr,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output logic [WAY_W-1:0]    rsp_way,
   output logic [TAG_W-1:0]    rsp_tag_value,
   output logic                rsp_fill_request,
   output logic [ADDR_W-1:0]   rsp_fill_addr,
   output logic                rsp_evicted,
   output logic [ADDR_W-1:0]   rsp_evicted_addr
);

   cmd_type cmd;

   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   sacl_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_addr         (req_addr),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_tag_value    (rsp_tag_value),
      .rsp_fill_request (rsp_fill_request),
      .rsp_fill_addr    (rsp_fill_addr),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_addr (rsp_evicted_addr)
   );

`ifndef ASSERT_OFF
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without an accepted transaction");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   a_hit_xor_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_hit != rsp_fill_request))
      else $error("hit and fill request disagree");

   a_no_evict_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> !rsp_evicted)
      else $error("eviction reported on a hit");
`endif

endmodule
